// File: rtl/fsbc_pkg.sv
// shared types and constants for the feistel s-box block cipher core
`timescale 1ns / 1ps

package fsbc_pkg;

	localparam int unsigned IdxW = 11;
	localparam int unsigned WordW = 32;

	localparam logic [IdxW-1:0] SUBKEY_COUNT = 11'd6;
	localparam logic [IdxW-1:0] SBOX0_BASE = 11'h012;
	localparam logic [IdxW-1:0] TABLE_DEPTH = 11'd1042;

	localparam int unsigned SBOX_COUNT = 4;
	localparam int unsigned SBOX_DEPTH = 256;
	localparam int unsigned ROUNDS = 4;
	// entry register, two registers per round, output register
	localparam int unsigned PIPE_DEPTH = 2 + 2 * ROUNDS;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_ENC  = 2'd1,
		FUNC_DEC  = 2'd2
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [IdxW-1:0]   table_index;
		logic [WordW-1:0]  table_word;
		logic [WordW-1:0]  left_word;
		logic [WordW-1:0]  right_word;
		logic              block_last;
	} cmd_t;

	typedef struct packed {
		logic [WordW-1:0]  out_left;
		logic [WordW-1:0]  out_right;
		logic              result_last;
	} res_t;

	// decoded item as it moves down the pipeline
	typedef struct packed {
		logic              crypt;
		logic              dec;
		logic              last;
		logic              ld_key;
		logic [2:0]        key_sel;
		logic              ld_sbox;
		logic [1:0]        sbox_sel;
		logic [7:0]        sbox_addr;
		logic [WordW-1:0]  word;
		logic [WordW-1:0]  x;
		logic [WordW-1:0]  y;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} link_t;

endpackage

// File: rtl/fsbc_entry.sv
// entry stage: decode of table loads and input whitening
`timescale 1ns / 1ps

module fsbc_entry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_take,
	input  fsbc_pkg::cmd_t     cmd,
	output fsbc_pkg::link_t    dn,
	input  logic               dn_take
);

	logic                   vld_s1;
	fsbc_pkg::item_t        item_s1;
	fsbc_pkg::item_t        dec_item;
	logic [31:0]            p0_q;
	logic [31:0]            p5_q;
	logic [10:0]            off;
	logic                   is_load;

	assign cmd_take = !vld_s1 || dn_take;

	always_comb begin
		is_load = (cmd.func == fsbc_pkg::FUNC_LOAD);
		off = cmd.table_index - fsbc_pkg::SBOX0_BASE;
		dec_item.crypt = (cmd.func == fsbc_pkg::FUNC_ENC) || (cmd.func == fsbc_pkg::FUNC_DEC);
		dec_item.dec = (cmd.func == fsbc_pkg::FUNC_DEC);
		dec_item.last = cmd.block_last;
		dec_item.ld_key = is_load && (cmd.table_index < fsbc_pkg::SUBKEY_COUNT);
		dec_item.key_sel = cmd.table_index[2:0];
		dec_item.ld_sbox = is_load && (cmd.table_index >= fsbc_pkg::SBOX0_BASE)
			&& (cmd.table_index < fsbc_pkg::TABLE_DEPTH);
		dec_item.sbox_sel = off[9:8];
		dec_item.sbox_addr = off[7:0];
		dec_item.word = cmd.table_word;
		// whitening with the first subkey of the chosen direction
		dec_item.x = cmd.left_word ^ (dec_item.dec ? p5_q : p0_q);
		dec_item.y = cmd.right_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_take) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			item_s1 <= dec_item;
		end
	end

	// local subkey copies, written as the load beat passes this stage
	always_ff @(posedge clk) begin
		if (cmd_take && cmd_valid && dec_item.ld_key) begin
			if (dec_item.key_sel == 3'd0) begin
				p0_q <= cmd.table_word;
			end
			if (dec_item.key_sel == 3'd5) begin
				p5_q <= cmd.table_word;
			end
		end
	end

	assign dn = '{vld: vld_s1, item: item_s1};

endmodule

// File: rtl/fsbc_round.sv
// one feistel round: s-box read stage followed by the f-function stage
`timescale 1ns / 1ps

module fsbc_round #(
	parameter int unsigned ROUND = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fsbc_pkg::link_t    up,
	output logic               up_take,
	output fsbc_pkg::link_t    dn,
	input  logic               dn_take
);

	localparam logic [2:0] EncSel = 3'(ROUND);
	localparam logic [2:0] DecSel = 3'(int'(fsbc_pkg::SUBKEY_COUNT) - 1 - int'(ROUND));

	logic                   vld_s1;
	logic                   vld_s2;
	fsbc_pkg::item_t        item_s1;
	fsbc_pkg::item_t        item_s2;
	fsbc_pkg::item_t        nxt;
	logic [31:0]            rd_s1 [fsbc_pkg::SBOX_COUNT];
	logic [31:0]            key_s1;
	logic [31:0]            kenc_q;
	logic [31:0]            kdec_q;
	logic [31:0]            f;
	logic                   take_a;
	logic                   take_b;

	assign take_b = !vld_s2 || dn_take;
	assign take_a = !vld_s1 || take_b;
	assign up_take = take_a;

	// this round's copy of the four s-boxes, loads and reads in beat order
	for (genvar g = 0; g < fsbc_pkg::SBOX_COUNT; g++) begin : g_sbox
		logic [31:0] mem_q [fsbc_pkg::SBOX_DEPTH];

		always_ff @(posedge clk) begin
			if (take_a) begin
				if (up.vld && up.item.ld_sbox && (up.item.sbox_sel == 2'(g))) begin
					mem_q[up.item.sbox_addr] <= up.item.word;
				end
				rd_s1[g] <= mem_q[up.item.x[8*(3-g) +: 8]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_a && up.vld && up.item.ld_key) begin
			if (up.item.key_sel == EncSel) begin
				kenc_q <= up.item.word;
			end
			if (up.item.key_sel == DecSel) begin
				kdec_q <= up.item.word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take_a) begin
				vld_s1 <= up.vld;
			end
			if (take_b) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_comb begin
		f = ((rd_s1[0] + rd_s1[1]) ^ rd_s1[2]) + rd_s1[3];
		nxt = item_s1;
		// new half goes to x for the next round, old x moves to y
		nxt.x = item_s1.y ^ f ^ key_s1;
		nxt.y = item_s1.x;
	end

	always_ff @(posedge clk) begin
		if (take_a) begin
			item_s1 <= up.item;
			key_s1 <= up.item.dec ? kdec_q : kenc_q;
		end
		if (take_b) begin
			item_s2 <= nxt;
		end
	end

	assign dn = '{vld: vld_s2, item: item_s2};

endmodule

// File: rtl/fsbc_exit.sv
// output register with the final subkey xor and half swap
`timescale 1ns / 1ps

module fsbc_exit (
	input  logic               clk,
	input  logic               arst_n,
	input  fsbc_pkg::link_t    up,
	output logic               up_take,
	output logic               res_valid,
	input  logic               res_stall,
	output fsbc_pkg::res_t     res
);

	logic                   res_vld_q;
	fsbc_pkg::res_t         res_q;
	logic [31:0]            p0_q;
	logic [31:0]            p5_q;

	assign up_take = !res_vld_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (up_take) begin
			// loads and unused codes end here without a result beat
			res_vld_q <= up.vld && up.item.crypt;
		end
	end

	always_ff @(posedge clk) begin
		if (up_take) begin
			res_q.out_left <= up.item.y ^ (up.item.dec ? p0_q : p5_q);
			res_q.out_right <= up.item.x;
			res_q.result_last <= up.item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (up_take && up.vld && up.item.ld_key) begin
			if (up.item.key_sel == 3'd0) begin
				p0_q <= up.item.word;
			end
			if (up.item.key_sel == 3'd5) begin
				p5_q <= up.item.word;
			end
		end
	end

	assign res_valid = res_vld_q;
	assign res = res_q;

endmodule

// File: rtl/feistel_sbox_block_cipher_core.sv
// top level of the four-round feistel s-box block cipher
//
//  channel | valid     | stall     | payload           | beat
//  --------+-----------+-----------+-------------------+-------------------------------
//  cmd     | cmd_valid | cmd_stall | fsbc_pkg::cmd_t   | table load or block to process
//  res     | res_valid | res_stall | fsbc_pkg::res_t   | processed block
//
// one beat per cycle in, one per cycle out while res_stall is low; res_valid follows the accepting
// edge through the entry register, two registers per round (s-box read, f-function) and the output
// register. every round holds its own copy of the s-boxes and subkeys, written as a load beat
// passes, so loads and blocks see the table in arrival order.
// reset clears only the valid bits; the key table is undefined until loaded.
// a stall fills bubbles upstream stage by stage; cmd_stall rises only when all stages are full.
`timescale 1ns / 1ps

module feistel_sbox_block_cipher_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  fsbc_pkg::cmd_t     cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output fsbc_pkg::res_t     res
);

	fsbc_pkg::link_t   link [fsbc_pkg::ROUNDS+1];
	logic              take [fsbc_pkg::ROUNDS+1];
	logic              cmd_take;

	assign cmd_stall = !cmd_take;

	fsbc_entry u_entry (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.dn        (link[0]),
		.dn_take   (take[0])
	);

	for (genvar r = 0; r < fsbc_pkg::ROUNDS; r++) begin : g_round
		fsbc_round #(
			.ROUND (r + 1)
		) u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.up      (link[r]),
			.up_take (take[r]),
			.dn      (link[r+1]),
			.dn_take (take[r+1])
		);
	end

	fsbc_exit u_exit (
		.clk       (clk),
		.arst_n    (arst_n),
		.up        (link[fsbc_pkg::ROUNDS]),
		.up_take   (take[fsbc_pkg::ROUNDS]),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// File: rtl/fsbc_checker.sv
// port-level checks for the cipher core and their binding
`timescale 1ns / 1ps

module fsbc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  fsbc_pkg::cmd_t     cmd,
	input  logic               res_valid,
	input  logic               res_stall,
	input  fsbc_pkg::res_t     res
);

	logic [3:0] pending_q;
	logic       crypt_in;
	logic       res_out;

	assign crypt_in = cmd_valid && !cmd_stall
		&& ((cmd.func == fsbc_pkg::FUNC_ENC) || (cmd.func == fsbc_pkg::FUNC_DEC));
	assign res_out = res_valid && !res_stall;

	// blocks accepted whose result beat has not gone yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else begin
			pending_q <= pending_q + 4'(crypt_in) - 4'(res_out);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("held result beat changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled while output is free");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 4'd0)
		else $error("result beat without an outstanding block");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(fsbc_pkg::PIPE_DEPTH))
		else $error("more blocks in flight than pipeline stages");

endmodule

bind feistel_sbox_block_cipher_core fsbc_checker u_checker (.*);
